@@ src/mcsr_pkg.sv @@
// Shared types and constants for the machine-mode CSR file.
// Used by mcsr_state and machine_csr_file in src; depends on nothing else.

package mcsr_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned ADDR_BITS = 12;
	localparam int unsigned OUT_CNT_BITS = 64;

	// CSR addresses.
	localparam logic [ADDR_BITS-1:0] ADDR_MSTATUS = 12'h300;
	localparam logic [ADDR_BITS-1:0] ADDR_MTVEC   = 12'h305;
	localparam logic [ADDR_BITS-1:0] ADDR_MEPC    = 12'h341;
	localparam logic [ADDR_BITS-1:0] ADDR_MCAUSE  = 12'h342;
	localparam logic [ADDR_BITS-1:0] ADDR_CYCLE   = 12'hC00;
	localparam logic [ADDR_BITS-1:0] ADDR_CYCLEH  = 12'hC80;

	// Bit positions of the single-bit fields.
	localparam int unsigned MIE_POS   = 3;
	localparam int unsigned CAUSE_POS = 31;

	// One input beat: one tick of the CSR file.
	typedef struct packed {
		logic                 sync_clear;
		logic                 read_enable;
		logic                 write_enable;
		logic [ADDR_BITS-1:0] csr_addr;
		logic [XLEN-1:0]      write_value;
		logic                 irq_request;
		logic                 save_pc;
		logic [XLEN-1:0]      pc_value;
		logic                 restore_pc;
	} item_t;

	// Result of one tick, apart from the counter value.
	typedef struct packed {
		logic [XLEN-1:0] read_value;
		logic            irq_enabled;
		logic            irq_pending;
		logic [XLEN-1:0] pc_restored;
	} result_t;

endpackage

@@ src/mcsr_counter.sv @@
// Cycle counter that steps on each advance, with synchronous clear.
// Uses nothing from the package; instantiated by machine_csr_file.

module mcsr_counter #(
	parameter int unsigned COUNTER_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    clear,
	output logic [COUNTER_BITS-1:0] count,
	output logic [COUNTER_BITS-1:0] count_next
);

	logic [COUNTER_BITS-1:0] count_q;

	// Wraps naturally at the counter width.
	assign count_next = clear ? '0 : count_q + COUNTER_BITS'(1);
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end

endmodule

@@ src/mcsr_state.sv @@
// Architectural CSR state, read mux and per-tick update logic.
// Depends on mcsr_pkg; instantiated by machine_csr_file.

module mcsr_state #(
	parameter int unsigned COUNTER_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  mcsr_pkg::item_t         item,
	input  logic [COUNTER_BITS-1:0] count,
	output mcsr_pkg::result_t       result
);

	logic                       mie_q;
	logic [mcsr_pkg::XLEN-1:0]  mtvec_q;
	logic [mcsr_pkg::XLEN-1:0]  mepc_q;
	logic                       cause_q;
	logic                       enable_q;
	logic [mcsr_pkg::XLEN-1:0]  pc_held_q;

	logic [mcsr_pkg::XLEN-1:0]  csr_rdata;
	logic [mcsr_pkg::XLEN-1:0]  count_hi;
	logic                       mie_d;
	logic [mcsr_pkg::XLEN-1:0]  mtvec_d;
	logic [mcsr_pkg::XLEN-1:0]  mepc_d;
	logic                       cause_d;
	logic                       enable_d;
	logic [mcsr_pkg::XLEN-1:0]  pc_held_d;

	assign count_hi = mcsr_pkg::XLEN'(count >> mcsr_pkg::XLEN);

	// Read mux sees the state as it stood before this tick.
	always_comb begin
		csr_rdata = '0;
		case (item.csr_addr)
			mcsr_pkg::ADDR_MSTATUS: csr_rdata[mcsr_pkg::MIE_POS]   = mie_q;
			mcsr_pkg::ADDR_MTVEC:   csr_rdata                      = mtvec_q;
			mcsr_pkg::ADDR_MEPC:    csr_rdata                      = mepc_q;
			mcsr_pkg::ADDR_MCAUSE:  csr_rdata[mcsr_pkg::CAUSE_POS] = cause_q;
			mcsr_pkg::ADDR_CYCLE:   csr_rdata = count[mcsr_pkg::XLEN-1:0];
			mcsr_pkg::ADDR_CYCLEH:  csr_rdata = count_hi;
			default:                csr_rdata = '0;
		endcase
	end

	// CSR writes first, then a pc save overrides mepc unless cleared.
	always_comb begin
		mie_d   = mie_q;
		mtvec_d = mtvec_q;
		mepc_d  = mepc_q;
		cause_d = cause_q;
		if (item.write_enable) begin
			case (item.csr_addr)
				mcsr_pkg::ADDR_MSTATUS: mie_d   = item.write_value[mcsr_pkg::MIE_POS];
				mcsr_pkg::ADDR_MTVEC:   mtvec_d = item.write_value;
				mcsr_pkg::ADDR_MEPC:    mepc_d  = item.write_value;
				mcsr_pkg::ADDR_MCAUSE:  cause_d = item.write_value[mcsr_pkg::CAUSE_POS];
				default:                mie_d   = mie_q;
			endcase
		end
		if (!item.sync_clear && item.save_pc) begin
			mepc_d = item.pc_value;
		end
	end

	assign enable_d  = item.sync_clear ? 1'b0 : mie_q;
	assign pc_held_d = item.sync_clear ? '0
	                 : (item.restore_pc ? mepc_d : pc_held_q);

	always_comb begin
		result.read_value  = item.read_enable ? csr_rdata : '0;
		result.irq_enabled = enable_d;
		result.irq_pending = !item.sync_clear && item.irq_request && enable_q && !cause_q;
		result.pc_restored = pc_held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mie_q     <= 1'b0;
			mtvec_q   <= '0;
			mepc_q    <= '0;
			cause_q   <= 1'b0;
			enable_q  <= 1'b0;
			pc_held_q <= '0;
		end else if (advance) begin
			mie_q     <= mie_d;
			mtvec_q   <= mtvec_d;
			mepc_q    <= mepc_d;
			cause_q   <= cause_d;
			enable_q  <= enable_d;
			pc_held_q <= pc_held_d;
		end
	end

endmodule

@@ src/machine_csr_file.sv @@
// Top level of the machine-mode CSR file: input stage, result stage, handshakes.
// Depends on mcsr_pkg, mcsr_counter and mcsr_state.
// A beat accepted into the input stage is executed, and its result registered into the
// result stage, as soon as the result stage is free to take it.
// Throughput: one beat per cycle while out_ready stays high; input and output stages stream back to back.
// Reset: arst_n clears all CSR state, the counter and both stage valid bits at once.

module machine_csr_file #(
	parameter int unsigned COUNTER_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        sync_clear,
	input  logic        read_enable,
	input  logic        write_enable,
	input  logic [11:0] csr_addr,
	input  logic [31:0] write_value,
	input  logic        irq_request,
	input  logic        save_pc,
	input  logic [31:0] pc_value,
	input  logic        restore_pc,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_value,
	output logic [63:0] cycle_total,
	output logic        irq_enabled,
	output logic        irq_pending,
	output logic [31:0] pc_restored
);

	// The input stage holds one beat. That beat is executed in the cycle it moves
	// to the result stage: the CSR state and the counter update at that same edge,
	// so the next beat in the input stage always sees the state left by this one.

	mcsr_pkg::item_t         item_s1;
	logic                    valid_s1;
	mcsr_pkg::result_t       res_s2;
	logic [mcsr_pkg::OUT_CNT_BITS-1:0] cycle_total_s2;
	logic                    valid_s2;

	mcsr_pkg::result_t       res_comb;
	logic [COUNTER_BITS-1:0] count;
	logic [COUNTER_BITS-1:0] count_next;
	logic                    take_s2;
	logic                    advance;

	// The result stage can take a new result when it is empty or being drained.
	assign take_s2  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && take_s2;
	assign in_ready = !valid_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.sync_clear   <= sync_clear;
			item_s1.read_enable  <= read_enable;
			item_s1.write_enable <= write_enable;
			item_s1.csr_addr     <= csr_addr;
			item_s1.write_value  <= write_value;
			item_s1.irq_request  <= irq_request;
			item_s1.save_pc      <= save_pc;
			item_s1.pc_value     <= pc_value;
			item_s1.restore_pc   <= restore_pc;
		end
	end

	mcsr_counter #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_counter (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.clear     (item_s1.sync_clear),
		.count     (count),
		.count_next(count_next)
	);

	mcsr_state #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.count  (count),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2         <= res_comb;
			cycle_total_s2 <= mcsr_pkg::OUT_CNT_BITS'(count_next);
		end
	end

	assign out_valid   = valid_s2;
	assign read_value  = res_s2.read_value;
	assign cycle_total = cycle_total_s2;
	assign irq_enabled = res_s2.irq_enabled;
	assign irq_pending = res_s2.irq_pending;
	assign pc_restored = res_s2.pc_restored;

	// A cleared tick must show zeroed counter, enable, pending and held pc.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.sync_clear |=> out_valid && cycle_total == '0
			&& !irq_enabled && !irq_pending && pc_restored == '0)
		else $error("cleared tick produced a nonzero result");

	// An empty input stage never blocks the input side.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// A result that is not taken is not dropped.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2)
		else $error("result stage lost a pending beat");

	// An executed beat shows up as valid in the result stage.
	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("executed beat did not reach the result stage");

endmodule

@@ bench/csr_file_checker.sv @@
`timescale 1ns / 100ps
// Checker for the machine-mode CSR file: watches both channels, predicts each result.
// Depends on mcsr_pkg for the CSR addresses, bit positions and the input beat type.

module csr_file_checker #(
	parameter int unsigned COUNTER_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        sync_clear,
	input  logic        read_enable,
	input  logic        write_enable,
	input  logic [11:0] csr_addr,
	input  logic [31:0] write_value,
	input  logic        irq_request,
	input  logic        save_pc,
	input  logic [31:0] pc_value,
	input  logic        restore_pc,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] read_value,
	input  logic [63:0] cycle_total,
	input  logic        irq_enabled,
	input  logic        irq_pending,
	input  logic [31:0] pc_restored,

	output int          fail_count,
	output int          outstanding,
	output int          checked_count,
	output int          pending_count
);

	typedef struct packed {
		logic [31:0] read_value;
		logic [63:0] cycle_total;
		logic        irq_enabled;
		logic        irq_pending;
		logic [31:0] pc_restored;
	} tick_result_t;

	localparam logic [63:0] COUNT_MASK = {64{1'b1}} >> (64 - COUNTER_BITS);

	// Predicted CSR file state.
	logic        mie_now      = 1'b0;
	logic [31:0] tvec_now     = '0;
	logic [31:0] epc_now      = '0;
	logic        cause_now    = 1'b0;
	logic [63:0] ticks_now    = '0;
	logic        enable_now   = 1'b0;
	logic [31:0] held_pc_now  = '0;

	tick_result_t    due_results[$];
	tick_result_t    want, got;
	mcsr_pkg::item_t beat;
	int              failures = 0;
	int              checked  = 0;
	int              pendings = 0;

	initial begin
		fail_count    = 0;
		outstanding   = 0;
		checked_count = 0;
		pending_count = 0;
	end

	function automatic logic [31:0] csr_lookup(input logic [11:0] addr);
		case (addr)
			mcsr_pkg::ADDR_MSTATUS: return 32'(mie_now) << mcsr_pkg::MIE_POS;
			mcsr_pkg::ADDR_MTVEC:   return tvec_now;
			mcsr_pkg::ADDR_MEPC:    return epc_now;
			mcsr_pkg::ADDR_MCAUSE:  return 32'(cause_now) << mcsr_pkg::CAUSE_POS;
			mcsr_pkg::ADDR_CYCLE:   return ticks_now[31:0];
			mcsr_pkg::ADDR_CYCLEH:  return ticks_now[63:32];
			default:                return '0;
		endcase
	endfunction

	task automatic predict_tick(input mcsr_pkg::item_t t, output tick_result_t r);
		logic [31:0] rdata;
		logic        old_mie;
		logic        pend;
		rdata   = t.read_enable ? csr_lookup(t.csr_addr) : '0;
		old_mie = mie_now;
		pend    = !t.sync_clear && t.irq_request && enable_now && !cause_now;
		if (t.write_enable) begin
			case (t.csr_addr)
				mcsr_pkg::ADDR_MSTATUS: mie_now   = t.write_value[mcsr_pkg::MIE_POS];
				mcsr_pkg::ADDR_MTVEC:   tvec_now  = t.write_value;
				mcsr_pkg::ADDR_MEPC:    epc_now   = t.write_value;
				mcsr_pkg::ADDR_MCAUSE:  cause_now = t.write_value[mcsr_pkg::CAUSE_POS];
				default: ;
			endcase
		end
		if (t.sync_clear) begin
			ticks_now   = '0;
			enable_now  = 1'b0;
			held_pc_now = '0;
		end else begin
			ticks_now  = (ticks_now + 64'd1) & COUNT_MASK;
			enable_now = old_mie;
			if (t.save_pc)
				epc_now = t.pc_value;
			if (t.restore_pc)
				held_pc_now = epc_now;
		end
		r.read_value  = rdata;
		r.cycle_total = ticks_now;
		r.irq_enabled = enable_now;
		r.irq_pending = pend;
		r.pc_restored = held_pc_now;
	endtask

	task automatic compare_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mie_now     = 1'b0;
			tvec_now    = '0;
			epc_now     = '0;
			cause_now   = 1'b0;
			ticks_now   = '0;
			enable_now  = 1'b0;
			held_pc_now = '0;
			due_results.delete();
		end else begin
			// Results leave before new beats enter, so the oldest expectation is used.
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					failures++;
				end else begin
					want = due_results.pop_front();
					got  = {read_value, cycle_total, irq_enabled, irq_pending, pc_restored};
					compare_field("read_value", 64'(want.read_value), 64'(got.read_value));
					compare_field("cycle_total", want.cycle_total, got.cycle_total);
					compare_field("irq_enabled", 64'(want.irq_enabled), 64'(got.irq_enabled));
					compare_field("irq_pending", 64'(want.irq_pending), 64'(got.irq_pending));
					compare_field("pc_restored", 64'(want.pc_restored), 64'(got.pc_restored));
					checked++;
					if (want.irq_pending)
						pendings++;
				end
			end
			if (in_valid && in_ready) begin
				beat = {sync_clear, read_enable, write_enable, csr_addr, write_value,
					irq_request, save_pc, pc_value, restore_pc};
				predict_tick(beat, want);
				due_results.push_back(want);
			end
		end
		fail_count    <= failures;
		outstanding   <= due_results.size();
		checked_count <= checked;
		pending_count <= pendings;
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Top of the machine_csr_file testbench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on mcsr_pkg, the machine_csr_file RTL and csr_file_checker.

module tb;

	localparam int unsigned CNT_BITS     = 64;
	localparam int          RANDOM_BEATS = 850;
	// Margin after the checker reports no results outstanding.
	localparam int          TAIL_CYCLES  = 8;
	// Watchdog limit, set far above the length of any honest run.
	localparam int          LIMIT_CYCLES = 200000;

	// Short names for single-bit flags in the directed beats.
	localparam logic LO = 1'b0;
	localparam logic HI = 1'b1;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;

	// Sender side. Everything starts at a known value before the first edge.
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic        sync_clear   = 1'b0;
	logic        read_enable  = 1'b0;
	logic        write_enable = 1'b0;
	logic [11:0] csr_addr     = '0;
	logic [31:0] write_value  = '0;
	logic        irq_request  = 1'b0;
	logic        save_pc      = 1'b0;
	logic [31:0] pc_value     = '0;
	logic        restore_pc   = 1'b0;

	// Receiver side.
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_value;
	logic [63:0] cycle_total;
	logic        irq_enabled;
	logic        irq_pending;
	logic [31:0] pc_restored;

	int fail_count;
	int outstanding;
	int checked_count;
	int pending_count;

	int beats_sent     = 0;
	int burst_left     = 0;
	int watchdog_ticks = 0;

	// Receiver stall pattern state.
	int       stall_mode = 0;
	int       stall_left = 0;
	bit [7:0] stall_phase = '0;

	always #4 clk = ~clk;

	machine_csr_file #(
		.COUNTER_BITS(CNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sync_clear(sync_clear),
		.read_enable(read_enable),
		.write_enable(write_enable),
		.csr_addr(csr_addr),
		.write_value(write_value),
		.irq_request(irq_request),
		.save_pc(save_pc),
		.pc_value(pc_value),
		.restore_pc(restore_pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.cycle_total(cycle_total),
		.irq_enabled(irq_enabled),
		.irq_pending(irq_pending),
		.pc_restored(pc_restored)
	);

	csr_file_checker #(
		.COUNTER_BITS(CNT_BITS)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sync_clear(sync_clear),
		.read_enable(read_enable),
		.write_enable(write_enable),
		.csr_addr(csr_addr),
		.write_value(write_value),
		.irq_request(irq_request),
		.save_pc(save_pc),
		.pc_value(pc_value),
		.restore_pc(restore_pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.cycle_total(cycle_total),
		.irq_enabled(irq_enabled),
		.irq_pending(irq_pending),
		.pc_restored(pc_restored),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked_count(checked_count),
		.pending_count(pending_count)
	);

	// The receiver switches between four stall styles for random stretches: always
	// ready, coin flip, mostly stalled, and a square-wave rhythm from bit 2 of a phase counter. The
	// always-ready style gives the stretches with no back-pressure at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(8, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= stall_phase[2];
		endcase
		stall_phase <= stall_phase + 8'd1;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		watchdog_ticks <= watchdog_ticks + 1;
		if (watchdog_ticks > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				watchdog_ticks, outstanding);
			$display("machine_csr_file test failed");
			$finish;
		end
	end

	function automatic mcsr_pkg::item_t make_tick(input logic clr, input logic rd,
			input logic wr, input logic [11:0] addr, input logic [31:0] wdata,
			input logic req, input logic save, input logic [31:0] pcv,
			input logic restore);
		mcsr_pkg::item_t t;
		t.sync_clear   = clr;
		t.read_enable  = rd;
		t.write_enable = wr;
		t.csr_addr     = addr;
		t.write_value  = wdata;
		t.irq_request  = req;
		t.save_pc      = save;
		t.pc_value     = pcv;
		t.restore_pc   = restore;
		return t;
	endfunction

	function automatic logic [11:0] known_csr(input int idx);
		case (idx)
			0: return mcsr_pkg::ADDR_MSTATUS;
			1: return mcsr_pkg::ADDR_MTVEC;
			2: return mcsr_pkg::ADDR_MEPC;
			3: return mcsr_pkg::ADDR_MCAUSE;
			4: return mcsr_pkg::ADDR_CYCLE;
			default: return mcsr_pkg::ADDR_CYCLEH;
		endcase
	endfunction

	// Most random beats hit a real CSR so that state is built up and read back.
	// Some use an address one bit away from a real one, to catch loose decoding,
	// and the rest are anywhere in the 12-bit space. Clears are kept rare so the
	// counter and the held pc get to run for a while between them.
	function automatic mcsr_pkg::item_t random_tick();
		mcsr_pkg::item_t t;
		int              pick;
		logic [11:0]     addr;
		pick = $urandom_range(0, 9);
		if (pick <= 6)
			addr = known_csr($urandom_range(0, 5));
		else if (pick == 7)
			addr = known_csr($urandom_range(0, 5)) ^ (12'd1 << $urandom_range(0, 11));
		else
			addr = 12'($urandom);
		t = make_tick(
			($urandom_range(0, 31) == 0),
			($urandom_range(0, 9) < 7),
			($urandom_range(0, 9) < 4),
			addr,
			$urandom,
			1'($urandom_range(0, 1)),
			($urandom_range(0, 6) == 0),
			$urandom,
			($urandom_range(0, 4) == 0));
		return t;
	endfunction

	// Sends one beat. Beats go out in bursts of random length; between bursts the
	// valid line drops for a random gap, and a zero gap runs two bursts together.
	// Valid and payload are held until the beat is taken.
	task automatic send_tick(input mcsr_pkg::item_t t);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		sync_clear   <= t.sync_clear;
		read_enable  <= t.read_enable;
		write_enable <= t.write_enable;
		csr_addr     <= t.csr_addr;
		write_value  <= t.write_value;
		irq_request  <= t.irq_request;
		save_pc      <= t.save_pc;
		pc_value     <= t.pc_value;
		restore_pc   <= t.restore_pc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// Directed opening: every CSR read and written at its extremes, the interrupt
	// pending path through enable and cause, the save-over-write priority on mepc,
	// writes to the read-only counters and to unknown addresses, and a clear that
	// drops a pc save but keeps a CSR write.
	task automatic run_directed();
		send_tick(make_tick(LO, HI, LO, mcsr_pkg::ADDR_MSTATUS, '0, LO, LO, '0, LO));
		// MIE set from an all-ones word; only bit 3 should stick.
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MSTATUS, '1, HI, LO, '0, LO));
		send_tick(make_tick(LO, HI, LO, mcsr_pkg::ADDR_MSTATUS, '0, HI, LO, '0, LO));
		// Registered enable is up now, cause is clear: the request shows as pending.
		send_tick(make_tick(LO, HI, LO, mcsr_pkg::ADDR_MCAUSE, '0, HI, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MCAUSE, 32'h8000_0000,
			HI, LO, '0, LO));
		// Cause bit set: the same request is masked.
		send_tick(make_tick(LO, HI, LO, mcsr_pkg::ADDR_MCAUSE, '0, HI, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MCAUSE, 32'h7FFF_FFFF,
			HI, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MTVEC, '1, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MTVEC, '0, LO, LO, '0, LO));
		// Pc save and CSR write to mepc in one beat: the save wins, and the restore
		// in the same beat already sees it.
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MEPC, 32'h1234_5678,
			LO, HI, '1, HI));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MEPC, '0, LO, LO, '0, HI));
		// Counter words ignore writes.
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_CYCLE, '1, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_CYCLEH, '1, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, LO, mcsr_pkg::ADDR_CYCLE, '0, LO, LO, '0, LO));
		// Unknown addresses at both ends of the space, and near misses.
		send_tick(make_tick(LO, HI, HI, 12'hFFF, '1, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, 12'h000, '1, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, 12'h301, '1, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, 12'h343, '1, LO, LO, '0, LO));
		// Clear with a save, a mepc write, a restore and a request all at once.
		send_tick(make_tick(HI, HI, HI, mcsr_pkg::ADDR_MEPC, 32'hA5A5_A5A5,
			HI, HI, 32'hDEAD_BEEF, HI));
		send_tick(make_tick(LO, HI, LO, mcsr_pkg::ADDR_MEPC, '0, HI, LO, '0, HI));
		// Read disabled returns zero even on a live CSR.
		send_tick(make_tick(LO, LO, LO, mcsr_pkg::ADDR_MTVEC, '0, LO, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MSTATUS, 32'h0000_0008,
			HI, LO, '0, LO));
		send_tick(make_tick(LO, HI, HI, mcsr_pkg::ADDR_MSTATUS, 32'hFFFF_FFF7,
			HI, LO, '0, LO));
		send_tick(make_tick(HI, HI, LO, mcsr_pkg::ADDR_CYCLEH, '0, LO, LO, '0, LO));
		send_tick(make_tick(HI, HI, LO, mcsr_pkg::ADDR_CYCLE, '0, LO, LO, '0, LO));
	endtask

	initial begin
		int directed_beats;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		directed_beats = beats_sent;
		for (int i = 0; i < RANDOM_BEATS; i++)
			send_tick(random_tick());
		in_valid <= 1'b0;

		// The checker's counts are registered, so wait for the next edge after the last beat.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d beats (%0d directed, %0d random) under random gaps and stalls.",
			beats_sent, directed_beats, beats_sent - directed_beats);
		$display("Checked %0d results, %0d of them with an interrupt pending; %0d mismatches.",
			checked_count, pending_count, fail_count);
		if (fail_count == 0)
			$display("machine_csr_file test passed");
		else
			$display("machine_csr_file test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/mcsr_pkg.sv
src/mcsr_counter.sv
src/mcsr_state.sv
src/machine_csr_file.sv
bench/csr_file_checker.sv
bench/tb.sv
